FILE: hdl/wsd_pkg.sv
package wsd_pkg;

   // field widths
   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;
   localparam int OPCODE_W = 4;
   localparam int LEN7_W = 7;
   localparam int LBL_W = 3;
   localparam int REM_W = 64;

   // result queue sizing, depth a power of two
   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // frame opcodes
   localparam logic [OPCODE_W-1:0] OP_TEXT = 4'h1;
   localparam logic [OPCODE_W-1:0] OP_CLOSE = 4'h8;

   // length byte escapes and extended length byte counts (minus one)
   localparam logic [LEN7_W-1:0] LEN_EXT16 = 7'd126;
   localparam logic [LEN7_W-1:0] LEN_EXT64 = 7'd127;
   localparam logic [LBL_W-1:0] LBL_EXT16 = 3'd1;
   localparam logic [LBL_W-1:0] LBL_EXT64 = 3'd7;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd2;

   typedef enum logic [3:0] {
      PH_HDR0 = 4'b0001,
      PH_LEN  = 4'b0010,
      PH_EXT  = 4'b0100,
      PH_BODY = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic              last;
   } rsp_word_type;

   // parser to queue
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } q_push_type;

   // queue head to output stage
   typedef struct packed {
      logic         valid;
      rsp_word_type word;
   } q_head_type;

endpackage

FILE: hdl/wsd_if.sv
interface wsd_req_if import wsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsd_rsp_if import wsd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] out_kind;
   logic [BYTE_W-1:0] out_byte;
   logic              out_last;

   modport source (output valid, output out_kind, output out_byte, output out_last,
                   input ready);
   modport sink (input valid, input out_kind, input out_byte, input out_last,
                 output ready);
endinterface

FILE: hdl/wsd_parser.sv
module wsd_parser import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   wsd_req_if.sink    req_ch,
   input  logic       q_full,
   output q_push_type push,
   output logic       closed
);

   phase_type           phase_ff, phase_in;
   logic [OPCODE_W-1:0] opcode_ff, opcode_in;
   logic [LBL_W-1:0]    lbl_ff, lbl_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic                closed_ff, closed_in;
   logic                accept;
   logic [LEN7_W-1:0]   len7;
   logic [REM_W-1:0]    rem_shift;
   logic                body_last;

   assign req_ch.ready = !q_full;
   assign accept = req_ch.valid && req_ch.ready;
   assign closed = closed_ff;

   assign len7 = req_ch.rx_byte[LEN7_W-1:0];
   assign rem_shift = {rem_ff[REM_W-BYTE_W-1:0], req_ch.rx_byte};
   assign body_last = (rem_ff == {{(REM_W-1){1'b0}}, 1'b1});

   // header and payload parsing, one word per cycle while the queue is not full
   always_comb begin
      phase_in = phase_ff;
      opcode_in = opcode_ff;
      lbl_in = lbl_ff;
      rem_in = rem_ff;
      closed_in = closed_ff;
      push = '0;
      if (accept && !closed_ff) begin
         unique case (phase_ff)
            PH_HDR0: begin
               opcode_in = req_ch.rx_byte[OPCODE_W-1:0];
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               rem_in = '0;
               if (len7 == LEN_EXT16) begin
                  lbl_in = LBL_EXT16;
                  phase_in = PH_EXT;
               end else if (len7 == LEN_EXT64) begin
                  lbl_in = LBL_EXT64;
                  phase_in = PH_EXT;
               end else begin
                  rem_in = {{(REM_W-LEN7_W){1'b0}}, len7};
                  if (len7 != '0) begin
                     phase_in = PH_BODY;
                  end else begin
                     phase_in = PH_HDR0;
                     if (opcode_ff == OP_TEXT) begin
                        push.valid = 1'b1;
                        push.word.kind = KIND_EMPTY;
                        push.word.last = 1'b1;
                     end else if (opcode_ff == OP_CLOSE) begin
                        push.valid = 1'b1;
                        push.word.kind = KIND_CLOSE;
                        push.word.last = 1'b1;
                        closed_in = 1'b1;
                     end
                  end
               end
            end
            PH_EXT: begin
               rem_in = rem_shift;
               if (lbl_ff != '0) begin
                  lbl_in = lbl_ff - 3'd1;
               end else if (rem_shift != '0) begin
                  phase_in = PH_BODY;
               end else begin
                  phase_in = PH_HDR0;
                  if (opcode_ff == OP_TEXT) begin
                     push.valid = 1'b1;
                     push.word.kind = KIND_EMPTY;
                     push.word.last = 1'b1;
                  end else if (opcode_ff == OP_CLOSE) begin
                     push.valid = 1'b1;
                     push.word.kind = KIND_CLOSE;
                     push.word.last = 1'b1;
                     closed_in = 1'b1;
                  end
               end
            end
            PH_BODY: begin
               rem_in = rem_ff - {{(REM_W-1){1'b0}}, 1'b1};
               if (body_last) begin
                  phase_in = PH_HDR0;
               end
               if (opcode_ff == OP_TEXT) begin
                  push.valid = 1'b1;
                  push.word.kind = KIND_BYTE;
                  push.word.data = req_ch.rx_byte;
                  push.word.last = body_last;
               end else if (opcode_ff == OP_CLOSE && body_last) begin
                  push.valid = 1'b1;
                  push.word.kind = KIND_CLOSE;
                  push.word.last = 1'b1;
                  closed_in = 1'b1;
               end
            end
            default: begin
               phase_in = PH_HDR0;
            end
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0;
         opcode_ff <= '0;
         lbl_ff <= '0;
         rem_ff <= '0;
         closed_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         opcode_ff <= opcode_in;
         lbl_ff <= lbl_in;
         rem_ff <= rem_in;
         closed_ff <= closed_in;
      end
   end

endmodule

FILE: hdl/wsd_queue.sv
module wsd_queue import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_push_type push,
   input  logic       pop,
   output q_head_type head,
   output logic       full
);

   rsp_word_type       entry_ff [QUEUE_DEPTH];
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign full = (count_ff == Q_CNT_W'(QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.word = entry_ff[rd_ptr_ff];

   assign do_push = push.valid && !full;
   assign do_pop = pop && head.valid;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.word;
      end
   end

endmodule

FILE: hdl/wsd_out.sv
module wsd_out import wsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  q_head_type head,
   output logic       pop,
   wsd_rsp_if.source  rsp_ch
);

   logic         valid_ff, valid_in;
   rsp_word_type word_ff;
   logic         load;

   // refill the output register when empty or when its word is taken
   assign load = head.valid && (!valid_ff || rsp_ch.ready);
   assign pop = load;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= head.word;
      end
   end

   assign rsp_ch.valid = valid_ff;
   assign rsp_ch.out_kind = word_ff.kind;
   assign rsp_ch.out_byte = word_ff.data;
   assign rsp_ch.out_last = word_ff.last;

endmodule

FILE: hdl/websocket_frame_deframer.sv
// WebSocket frame deframer, server to client direction.
// req_ch carries the received stream, one rx_byte per word. Frame headers
// (opcode byte, 7-bit length, optional 16 or 64-bit extended length) are
// parsed and the payload is counted through.
// rsp_ch carries at most one word per input word: a text payload byte
// (out_last on the final one), an empty text message, or a close report.
// Other frames are consumed without output; after a close every word is
// dropped until reset.
// Throughput: one word per cycle while the queue is not full, set by the
// header/length parser. An accepted word's result reaches rsp_ch through
// a two-entry queue and then the output register.
// Reset (synchronous, active high) returns the parser to the first header
// byte, reopens the stream and empties the queue and output register.
// When the receiver stalls, the output register holds its word and the
// queue fills; req_ch.ready drops only once the queue is full.
module websocket_frame_deframer import wsd_pkg::*; (
   input logic       clock,
   input logic       reset,
   wsd_req_if.sink   req_ch,
   wsd_rsp_if.source rsp_ch
);

   q_push_type push;
   q_head_type head;
   logic       q_full;
   logic       pop;
   logic       parser_closed;

   wsd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .q_full (q_full),
      .push   (push),
      .closed (parser_closed)
   );

   wsd_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (q_full)
   );

   wsd_out u_out (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   // no result is ever produced once the stream is closed
   assert property (@(posedge clock) disable iff (reset)
      parser_closed |-> !push.valid)
      else $error("result produced after close");

   // the parser never pushes into a full queue
   assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !q_full)
      else $error("push into full queue");

   // non-byte results are always last and carry zero data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.out_kind != KIND_BYTE) |->
         (rsp_ch.out_last && rsp_ch.out_byte == '0))
      else $error("bad empty or close result");

   // output is empty right after reset
   assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("output valid after reset");

endmodule
